// ----- rtl/core/qsfb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qsfb_pkg
// Types and constants shared by the symbol frame builder modules.
// ----------------------------------------------------------------------------
package qsfb_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned SumW   = 16;
    localparam int unsigned SymW   = 2;
    localparam int unsigned IdxW   = 5;

    localparam logic [SymW-1:0] FRAME_SYNC = 2'b11;

    // Symbol slots within one item's sequence
    localparam logic [IdxW-1:0] IDX_SYNC   = 5'd0;
    localparam logic [IdxW-1:0] IDX_LEN0   = 5'd1;
    localparam logic [IdxW-1:0] IDX_LEN1   = 5'd2;
    localparam logic [IdxW-1:0] IDX_LEN2   = 5'd3;
    localparam logic [IdxW-1:0] IDX_LEN3   = 5'd4;
    localparam logic [IdxW-1:0] IDX_DATA0  = 5'd5;
    localparam logic [IdxW-1:0] IDX_DATA1  = 5'd6;
    localparam logic [IdxW-1:0] IDX_DATA2  = 5'd7;
    localparam logic [IdxW-1:0] IDX_DATA3  = 5'd8;
    localparam logic [IdxW-1:0] IDX_CK0    = 5'd9;
    localparam logic [IdxW-1:0] IDX_CK1    = 5'd10;
    localparam logic [IdxW-1:0] IDX_CK2    = 5'd11;
    localparam logic [IdxW-1:0] IDX_CK3    = 5'd12;
    localparam logic [IdxW-1:0] IDX_CK4    = 5'd13;
    localparam logic [IdxW-1:0] IDX_CK5    = 5'd14;
    localparam logic [IdxW-1:0] IDX_CK6    = 5'd15;
    localparam logic [IdxW-1:0] IDX_CK7    = 5'd16;

    typedef struct packed {
        logic [ByteW-1:0] data_byte;
        logic [ByteW-1:0] msg_length;
    } t_in_item;

    typedef struct packed {
        logic [SymW-1:0] symbol;
        logic            frame_end;
        logic            run_last;
    } t_out_item;

    typedef struct packed {
        logic [ByteW-1:0] data_byte;
        logic [ByteW-1:0] msg_length;
        logic             header;
        logic             zero_len;
        logic             trailer;
        logic [SumW-1:0]  checksum;
    } t_desc;

endpackage
`default_nettype wire

// ----- rtl/core/qsfb_prep.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qsfb_prep
// Input register: latches one byte, updates position, length and checksum
// state, and holds the descriptor the sequencer walks through.
// ----------------------------------------------------------------------------
module qsfb_prep
    import qsfb_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_take,
    input  wire t_in_item i_item,
    output t_desc         o_desc
);

    logic [ByteW-1:0] r_pos, n_pos;
    logic [ByteW-1:0] r_len, n_len;
    logic [SumW-1:0]  r_sum, n_sum;
    t_desc            r_desc, n_desc;

    logic [SumW-1:0]  base;
    logic [SumW-1:0]  total;
    logic [3:0]       dsum;
    logic [ByteW-1:0] pos_inc;
    logic             hdr;
    logic             zero;
    logic             done;

    always_comb begin
        hdr     = (r_pos == '0);
        zero    = hdr && (i_item.msg_length == '0);
        n_len   = hdr ? i_item.msg_length : r_len;
        base    = hdr ? {{(SumW-ByteW){1'b0}}, i_item.msg_length} : r_sum;
        dsum    = {2'b00, i_item.data_byte[7:6]} + {2'b00, i_item.data_byte[5:4]}
                + {2'b00, i_item.data_byte[3:2]} + {2'b00, i_item.data_byte[1:0]};
        total   = zero ? base : base + {{(SumW-4){1'b0}}, dsum};
        pos_inc = r_pos + 8'd1;
        done    = !zero && (pos_inc == n_len);

        n_pos = (zero || done) ? '0 : pos_inc;
        n_sum = (zero || done) ? '0 : total;

        n_desc.data_byte  = i_item.data_byte;
        n_desc.msg_length = i_item.msg_length;
        n_desc.header     = hdr;
        n_desc.zero_len   = zero;
        n_desc.trailer    = done;
        n_desc.checksum   = total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_len <= '0;
            r_sum <= '0;
        end else if (i_take) begin
            r_pos <= n_pos;
            r_len <= n_len;
            r_sum <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_desc <= n_desc;
        end
    end

    assign o_desc = r_desc;

endmodule
`default_nettype wire

// ----- rtl/core/qsfb_seq.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qsfb_seq
// Symbol sequencer and result register: walks header, data and checksum
// slots of the held descriptor, one symbol per transfer.
// ----------------------------------------------------------------------------
module qsfb_seq
    import qsfb_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_take,
    input  wire t_desc i_desc,
    input  wire logic  i_stall,
    output logic       o_ready,
    output logic       o_busy,
    output logic       o_valid,
    output t_out_item  o_res
);

    logic            r_busy;
    logic            r_fresh;
    logic [IdxW-1:0] r_idx, n_idx;
    logic            r_valid;
    t_out_item       r_res, n_res;

    logic [IdxW-1:0] cur;
    logic            adv;
    logic            last;
    logic [SymW-1:0] sym;

    always_comb begin
        cur  = r_fresh ? (i_desc.header ? IDX_SYNC : IDX_DATA0) : r_idx;
        adv  = r_busy && (!r_valid || !i_stall);
        last = (cur == IDX_CK7) || ((cur == IDX_DATA3) && !i_desc.trailer);

        if ((cur == IDX_LEN3) && i_desc.zero_len) begin
            n_idx = IDX_CK0;
        end else begin
            n_idx = cur + 5'd1;
        end

        case (cur)
            IDX_SYNC:  sym = FRAME_SYNC;
            IDX_LEN0:  sym = i_desc.msg_length[7:6];
            IDX_LEN1:  sym = i_desc.msg_length[5:4];
            IDX_LEN2:  sym = i_desc.msg_length[3:2];
            IDX_LEN3:  sym = i_desc.msg_length[1:0];
            IDX_DATA0: sym = i_desc.data_byte[7:6];
            IDX_DATA1: sym = i_desc.data_byte[5:4];
            IDX_DATA2: sym = i_desc.data_byte[3:2];
            IDX_DATA3: sym = i_desc.data_byte[1:0];
            IDX_CK0:   sym = i_desc.checksum[15:14];
            IDX_CK1:   sym = i_desc.checksum[13:12];
            IDX_CK2:   sym = i_desc.checksum[11:10];
            IDX_CK3:   sym = i_desc.checksum[9:8];
            IDX_CK4:   sym = i_desc.checksum[7:6];
            IDX_CK5:   sym = i_desc.checksum[5:4];
            IDX_CK6:   sym = i_desc.checksum[3:2];
            IDX_CK7:   sym = i_desc.checksum[1:0];
            default:   sym = '0;
        endcase

        n_res.symbol    = sym;
        n_res.frame_end = (cur == IDX_CK7);
        n_res.run_last  = last;

        o_ready = !r_busy || (adv && last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_fresh <= 1'b0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_take) begin
                r_busy  <= 1'b1;
                r_fresh <= 1'b1;
            end else if (adv) begin
                r_fresh <= 1'b0;
                r_idx   <= n_idx;
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
            if (!r_valid || !i_stall) begin
                r_valid <= adv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= n_res;
        end
    end

    assign o_busy  = r_busy;
    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule
`default_nettype wire

// ----- rtl/core/qam_symbol_frame_builder_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qam_symbol_frame_builder_unit
// A byte is held in the input register, then its first symbol is loaded into the
// result register; one symbol per cycle while the receiver does not stall.
// A byte yields 4, 9, 12, 13 or 17 symbols, one per result register load.
// The next byte is taken in the cycle its predecessor's last symbol is loaded.
// Reset (synchronous, active low) clears position, length, sum and valids.
// ----------------------------------------------------------------------------
module qam_symbol_frame_builder_unit
    import qsfb_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_in_item i_item,
    output logic          o_valid,
    input  wire logic     i_stall,
    output t_out_item     o_res
);

    t_desc desc;
    logic  ready;
    logic  busy;
    logic  take;

    assign take    = i_valid && ready;
    assign o_stall = !ready;

    qsfb_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_item  (i_item),
        .o_desc  (desc)
    );

    qsfb_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_desc  (desc),
        .i_stall (i_stall),
        .o_ready (ready),
        .o_busy  (busy),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.frame_end |-> o_res.run_last)
        else $error("frame end without run last");

    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> busy)
        else $error("sequencer idle after transfer");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !busy)
        else $error("activity after reset");

endmodule
`default_nettype wire

// ----- tb/qam_symbol_frame_builder_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qam_symbol_frame_builder_unit_tb
// Drives message bytes into the frame builder and checks every symbol it
// emits against an in-bench model of the framing: sync, length, data and
// checksum symbols with their frame-end and last-of-byte flags. Runs a short
// directed set, then random messages under several sender and receiver
// idling mixes, a long receiver hold-off and the opening bytes of a
// maximum-length message.
// ----------------------------------------------------------------------------
module qam_symbol_frame_builder_unit_tb;
    import qsfb_pkg::*;

    localparam int unsigned CycleLimit = 500000;
    localparam int unsigned DrainCycles = 40;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_item  i_item = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_item o_res;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_req = 0;
    int unsigned cycle_count = 0;
    int unsigned err_count = 0;

    logic [ByteW-1:0] frame_pos = '0;
    logic [ByteW-1:0] frame_len = '0;
    logic [SumW-1:0]  frame_sum = '0;
    t_out_item        expected_symbols[$];
    t_out_item        want;

    qam_symbol_frame_builder_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (o_res)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("qam_symbol_frame_builder_unit_tb: done, errors");
            $finish;
        end
    end

    // hold off for the requested stretch, otherwise stall at random
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            i_stall <= 1'b1;
            hold_req--;
        end else begin
            i_stall <= ($urandom_range(99, 0) < recv_stall_pct);
        end
    end

    function automatic t_out_item make_symbol(logic [SymW-1:0] sym, logic fend);
        t_out_item r;
        r.symbol    = sym;
        r.frame_end = fend;
        r.run_last  = 1'b0;
        return r;
    endfunction

    task automatic push_checksum();
        for (int i = 0; i < 8; i++) begin
            expected_symbols.push_back(
                make_symbol(frame_sum[14 - 2*i +: 2], (i == 7)));
        end
        frame_pos = '0;
        frame_sum = '0;
    endtask

    task automatic predict_byte(input t_in_item item);
        logic [SymW-1:0] sym;
        t_out_item       last;
        logic            done;
        done = 1'b0;
        if (frame_pos == '0) begin
            frame_len = item.msg_length;
            expected_symbols.push_back(make_symbol(FRAME_SYNC, 1'b0));
            for (int i = 0; i < 4; i++) begin
                expected_symbols.push_back(
                    make_symbol(item.msg_length[6 - 2*i +: 2], 1'b0));
            end
            frame_sum = SumW'(item.msg_length);
            if (item.msg_length == '0) begin
                push_checksum();
                done = 1'b1;
            end
        end
        if (!done) begin
            for (int i = 0; i < 4; i++) begin
                sym = item.data_byte[6 - 2*i +: 2];
                expected_symbols.push_back(make_symbol(sym, 1'b0));
                frame_sum = frame_sum + SumW'(sym);
            end
            frame_pos = frame_pos + 8'd1;
            if (frame_pos == frame_len) push_checksum();
        end
        last = expected_symbols.pop_back();
        last.run_last = 1'b1;
        expected_symbols.push_back(last);
    endtask

    // enter and leave at a falling edge
    task automatic send_byte(input logic [ByteW-1:0] data, input logic [ByteW-1:0] len);
        t_in_item item;
        item.data_byte  = data;
        item.msg_length = len;
        while ($urandom_range(99, 0) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= item;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        predict_byte(item);
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (expected_symbols.size() == 0) begin
                $error("unexpected symbol transfer: symbol %0d", o_res.symbol);
                err_count++;
            end else begin
                want = expected_symbols.pop_front();
                if (o_res.symbol !== want.symbol) begin
                    $error("symbol: expected %0d, got %0d", want.symbol, o_res.symbol);
                    err_count++;
                end
                if (o_res.frame_end !== want.frame_end) begin
                    $error("frame_end: expected %0d, got %0d",
                           want.frame_end, o_res.frame_end);
                    err_count++;
                end
                if (o_res.run_last !== want.run_last) begin
                    $error("run_last: expected %0d, got %0d",
                           want.run_last, o_res.run_last);
                    err_count++;
                end
            end
        end
    end

    function automatic logic [ByteW-1:0] pick_length();
        int unsigned roll;
        roll = $urandom_range(99, 0);
        if (roll < 10) return '0;
        if (roll < 85) return ByteW'($urandom_range(6, 1));
        return ByteW'($urandom_range(40, 7));
    endfunction

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_byte(8'hA5, 8'd0);
        send_byte(8'hFF, 8'd1);
        send_byte(8'h00, 8'd1);
        send_byte(8'h1B, 8'd3);
        send_byte(8'hE4, 8'hFF);
        send_byte(8'h55, 8'h00);
        send_byte(8'hAA, 8'd2);
        send_byte(8'h33, 8'h00);
        send_byte(8'hFF, 8'd0);
        send_byte(8'h00, 8'd4);
        send_byte(8'hFF, 8'h55);
        send_byte(8'hC6, 8'd128);
        send_byte(8'h39, 8'd64);
        send_byte(8'h00, 8'd1);
    endtask

    task automatic test_random(input int unsigned n_items, input int unsigned send_pct,
                               input int unsigned recv_pct);
        logic [ByteW-1:0] len;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int n = 0; n < n_items; n++) begin
            len = (frame_pos == '0) ? pick_length() : ByteW'($urandom);
            send_byte(ByteW'($urandom), len);
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(posedge i_clk);
        hold_req = 300;
        @(negedge i_clk);
        for (int n = 0; n < 12; n++) begin
            send_byte(ByteW'($urandom), (frame_pos == '0) ? 8'd9 : ByteW'($urandom));
        end
    endtask

    task automatic test_max_length();
        send_idle_pct  = 14;
        recv_stall_pct = 14;
        while (frame_pos != '0) send_byte(ByteW'($urandom), ByteW'($urandom));
        send_byte(ByteW'($urandom), 8'd255);
        for (int n = 0; n < 8; n++) begin
            send_byte(ByteW'($urandom), ByteW'($urandom));
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random(15, 0, 0);
        test_random(15, 77, 0);
        test_random(15, 0, 77);
        test_random(15, 14, 14);
        test_backpressure();
        test_max_length();

        i_valid <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (expected_symbols.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (err_count == 0) begin
            $display("qam_symbol_frame_builder_unit_tb: done, clean");
        end else begin
            $display("qam_symbol_frame_builder_unit_tb: done, errors");
        end
        $finish;
    end

endmodule

// ----- qam_symbol_frame_builder_unit.f -----
rtl/core/qsfb_pkg.sv
rtl/core/qsfb_prep.sv
rtl/core/qsfb_seq.sv
rtl/core/qam_symbol_frame_builder_unit.sv
tb/qam_symbol_frame_builder_unit_tb.sv
